FILE: rtl/core/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Types and constants shared by the pixel swizzle / unpremultiply pipeline.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int unsigned CHAN_WIDTH = 8;
   localparam int unsigned NUM_CHANS  = 3;
   localparam int unsigned NUM_WIDTH  = 16;
   localparam int unsigned DIV_BITS   = 8;
   localparam int unsigned CSR_IDX_WIDTH  = 2;
   localparam int unsigned CSR_DATA_WIDTH = 2;

   localparam logic [1:0] FMT_BGR  = 2'd0;
   localparam logic [1:0] FMT_BGRA = 2'd1;
   localparam logic [1:0] FMT_RGBA = 2'd2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SOURCE_FORMAT        = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALPHA_OUT_ENABLE     = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SOURCE_PREMULTIPLIED = 2'd2;

   localparam logic [1:0] SEL_PASS = 2'd0;
   localparam logic [1:0] SEL_ZERO = 2'd1;
   localparam logic [1:0] SEL_DIV  = 2'd2;

   localparam logic [CHAN_WIDTH-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [1:0] source_format;
      logic       alpha_out_enable;
      logic       source_premultiplied;
   } psu_cfg_type;

   // Swizzled pixel, before the numerator is formed.
   typedef struct packed {
      logic [NUM_CHANS-1:0][CHAN_WIDTH-1:0] color;
      logic [CHAN_WIDTH-1:0]                alpha;
      logic                                 alpha_en;
      logic                                 unpremul;
   } psu_pix_type;

   // Item moving through the divider stages. Channel 0 blue, 1 green, 2 red.
   typedef struct packed {
      logic [NUM_CHANS-1:0][CHAN_WIDTH-1:0] color;
      logic [CHAN_WIDTH-1:0]                alpha;
      logic                                 alpha_en;
      logic [1:0]                           sel;
      logic [NUM_CHANS-1:0]                 sat;
      logic [NUM_CHANS-1:0][NUM_WIDTH-1:0]  rem;
      logic [NUM_CHANS-1:0][DIV_BITS-1:0]   quot;
   } psu_work_type;

endpackage

FILE: rtl/core/psu_if.sv
// ----------------------------------------------------------------------------
// psu channel interfaces
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_zero;
   logic [7:0] byte_one;
   logic [7:0] byte_two;
   logic [7:0] byte_three;

   modport source (output valid, byte_zero, byte_one, byte_two, byte_three, input ready);
   modport sink   (input valid, byte_zero, byte_one, byte_two, byte_three, output ready);
endinterface

interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue_out;
   logic [7:0] green_out;
   logic [7:0] red_out;
   logic [7:0] alpha_out;
   logic       alpha_present;

   modport source (output valid, blue_out, green_out, red_out, alpha_out, alpha_present,
                   input ready);
   modport sink   (input valid, blue_out, green_out, red_out, alpha_out, alpha_present,
                   output ready);
endinterface

interface psu_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front
// Two stages: byte swizzle and alpha pick, then numerator v*255 + a/2,
// saturation test and result select.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  psu_cfg_type           cfg,
   input  logic                  in_valid,
   input  logic [CHAN_WIDTH-1:0] byte_zero,
   input  logic [CHAN_WIDTH-1:0] byte_one,
   input  logic [CHAN_WIDTH-1:0] byte_two,
   input  logic [CHAN_WIDTH-1:0] byte_three,
   output logic                  up_ready,
   input  logic                  down_ready,
   output logic                  out_valid,
   output psu_work_type          out_data
);

   logic         pix_valid_ff;
   psu_pix_type  pix_ff;
   psu_pix_type  pix_in;
   logic         pix_adv;

   logic         work_valid_ff;
   psu_work_type work_ff;
   psu_work_type work_in;
   logic         work_adv;

   logic [NUM_WIDTH-1:0] alpha_shl;

   assign work_adv = !work_valid_ff || down_ready;
   assign pix_adv  = !pix_valid_ff || work_adv;
   assign up_ready = pix_adv;

   always_comb begin
      pix_in          = '0;
      pix_in.color[1] = byte_one;
      case (cfg.source_format)
         FMT_RGBA: begin
            pix_in.color[0] = byte_two;
            pix_in.color[2] = byte_zero;
            pix_in.alpha    = byte_three;
         end
         FMT_BGR: begin
            pix_in.color[0] = byte_zero;
            pix_in.color[2] = byte_two;
            pix_in.alpha    = ALPHA_OPAQUE;
         end
         default: begin
            pix_in.color[0] = byte_zero;
            pix_in.color[2] = byte_two;
            pix_in.alpha    = byte_three;
         end
      endcase
      pix_in.alpha_en = cfg.alpha_out_enable;
      pix_in.unpremul = cfg.alpha_out_enable && cfg.source_premultiplied;
   end

   assign alpha_shl = {pix_ff.alpha, 8'h00};

   always_comb begin
      work_in          = '0;
      work_in.color    = pix_ff.color;
      work_in.alpha    = pix_ff.alpha;
      work_in.alpha_en = pix_ff.alpha_en;
      if (!pix_ff.unpremul || pix_ff.alpha == ALPHA_OPAQUE) begin
         work_in.sel = SEL_PASS;
      end else if (pix_ff.alpha == '0) begin
         work_in.sel = SEL_ZERO;
      end else begin
         work_in.sel = SEL_DIV;
      end
      for (int c = 0; c < NUM_CHANS; c++) begin
         work_in.rem[c] = ({pix_ff.color[c], 8'h00} - {8'h00, pix_ff.color[c]})
                          + {9'd0, pix_ff.alpha[7:1]};
         work_in.sat[c] = work_in.rem[c] >= alpha_shl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff  <= 1'b0;
         work_valid_ff <= 1'b0;
      end else begin
         if (pix_adv) begin
            pix_valid_ff <= in_valid;
         end
         if (work_adv) begin
            work_valid_ff <= pix_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_adv) begin
         pix_ff <= pix_in;
      end
      if (work_adv) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = work_valid_ff;
   assign out_data  = work_ff;

endmodule

FILE: rtl/core/psu_div_step.sv
// ----------------------------------------------------------------------------
// psu_div_step
// One restoring division stage: resolves quotient bit BIT for all three
// colour channels with one compare and subtract each.
// ----------------------------------------------------------------------------
module psu_div_step import psu_pkg::*; #(
   parameter int unsigned BIT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  psu_work_type in_data,
   output logic         up_ready,
   input  logic         down_ready,
   output logic         out_valid,
   output psu_work_type out_data
);

   logic                 valid_ff;
   psu_work_type         data_ff;
   psu_work_type         data_in;
   logic                 adv;
   logic [NUM_WIDTH-1:0] divisor;

   assign adv      = !valid_ff || down_ready;
   assign up_ready = adv;
   assign divisor  = {8'h00, in_data.alpha} << BIT;

   always_comb begin
      data_in = in_data;
      for (int c = 0; c < NUM_CHANS; c++) begin
         if (in_data.rem[c] >= divisor) begin
            data_in.rem[c]       = in_data.rem[c] - divisor;
            data_in.quot[c][BIT] = 1'b1;
         end else begin
            data_in.quot[c][BIT] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/core/pixel_swizzle_unpremultiply.sv
// ----------------------------------------------------------------------------
// pixel_swizzle_unpremultiply
// Reorders a source pixel to blue, green, red with optional alpha, and
// undoes alpha premultiplication with a bit-per-stage divider pipeline.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        byte_zero, byte_one, byte_two, byte_three
//   rsp      out  valid/ready        blue_out, green_out, red_out, alpha_out,
//                                    alpha_present
//   csr      in   valid/ready (=1)   index, data
//
// One item per clock sustained while rsp.ready stays high; the path from accept to
// rsp.valid runs through 2 front stages, 8 divider stages and 1 output register.
// Every stage holds its item while the next one is full and stalled; ready
// ripples back stage by stage, so bubbles are squeezed out.
// Synchronous reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module pixel_swizzle_unpremultiply import psu_pkg::*; (
   input logic        clock,
   input logic        reset,
   psu_req_if.sink    req,
   psu_rsp_if.source  rsp,
   psu_csr_if.sink    csr
);

   psu_cfg_type  cfg_ff;

   logic         front_valid;
   psu_work_type front_data;
   logic         front_down_ready;

   logic         div_valid [0:DIV_BITS];
   psu_work_type div_data  [0:DIV_BITS];
   logic         div_ready [0:DIV_BITS];

   logic         out_valid_ff;
   logic         out_adv;
   logic [NUM_CHANS-1:0][CHAN_WIDTH-1:0] color_in;
   logic [NUM_CHANS-1:0][CHAN_WIDTH-1:0] color_ff;
   logic [CHAN_WIDTH-1:0] alpha_ff;
   logic                  alpha_present_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format        <= FMT_BGRA;
         cfg_ff.alpha_out_enable     <= 1'b0;
         cfg_ff.source_premultiplied <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SOURCE_FORMAT:        cfg_ff.source_format        <= csr.data;
            CSR_ALPHA_OUT_ENABLE:     cfg_ff.alpha_out_enable     <= csr.data[0];
            CSR_SOURCE_PREMULTIPLIED: cfg_ff.source_premultiplied <= csr.data[0];
            default: ;
         endcase
      end
   end

   psu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req.valid),
      .byte_zero  (req.byte_zero),
      .byte_one   (req.byte_one),
      .byte_two   (req.byte_two),
      .byte_three (req.byte_three),
      .up_ready   (req.ready),
      .down_ready (front_down_ready),
      .out_valid  (front_valid),
      .out_data   (front_data)
   );

   assign div_valid[0]     = front_valid;
   assign div_data[0]      = front_data;
   assign front_down_ready = div_ready[0];
   assign div_ready[DIV_BITS] = out_adv;

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      psu_div_step #(.BIT(DIV_BITS - 1 - j)) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (div_valid[j]),
         .in_data    (div_data[j]),
         .up_ready   (div_ready[j]),
         .down_ready (div_ready[j+1]),
         .out_valid  (div_valid[j+1]),
         .out_data   (div_data[j+1])
      );
   end

   assign out_adv = !out_valid_ff || rsp.ready;

   always_comb begin
      for (int c = 0; c < NUM_CHANS; c++) begin
         case (div_data[DIV_BITS].sel)
            SEL_ZERO: color_in[c] = '0;
            SEL_DIV:  color_in[c] = div_data[DIV_BITS].sat[c] ? ALPHA_OPAQUE
                                                              : div_data[DIV_BITS].quot[c];
            default:  color_in[c] = div_data[DIV_BITS].color[c];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= div_valid[DIV_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         color_ff         <= color_in;
         alpha_ff         <= div_data[DIV_BITS].alpha;
         alpha_present_ff <= div_data[DIV_BITS].alpha_en;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.blue_out      = color_ff[0];
   assign rsp.green_out     = color_ff[1];
   assign rsp.red_out       = color_ff[2];
   assign rsp.alpha_out     = alpha_ff;
   assign rsp.alpha_present = alpha_present_ff;

endmodule
